@@ src/nearest_lattice_atom_search_top_macros.svh @@
// assertion macros for the nearest lattice atom search checker
// no dependencies
`ifndef NEAREST_LATTICE_ATOM_SEARCH_TOP_MACROS_SVH
`define NEAREST_LATTICE_ATOM_SEARCH_TOP_MACROS_SVH
`define NLAS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nlas check failed");
`define NLAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nlas check failed");
`endif

@@ src/nlas_pkg.sv @@
// package for the nearest lattice atom search block
// shared types, constants and a helper function; no dependencies
package nlas_pkg;
  localparam int MAX_BASIS = 16;
  localparam int FRAC_W = 12;
  localparam int POS_W = 20;
  localparam int IDX_W = 12;
  localparam int INV_FRAC = 16;
  localparam int CFG_W = 60;
  localparam int BASIS_W = 36;
  localparam int IN_TDATA_W = 104;
  localparam int OUT_TDATA_W = 96;
  localparam int CART_W = 56;
  localparam int DIST_W = 2 * CART_W + 2;

  typedef enum logic [2:0] {
    REG_LATTICE_A = 3'd0,
    REG_LATTICE_B = 3'd1,
    REG_LATTICE_C = 3'd2,
    REG_INVERSE_0 = 3'd3,
    REG_INVERSE_1 = 3'd4,
    REG_INVERSE_2 = 3'd5,
    REG_ORIGIN    = 3'd6,
    REG_ATOMS     = 3'd7
  } reg_index_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_MUL, ST_ROUND, ST_READ, ST_CART, ST_SUM, ST_DIST, ST_CMP, ST_OUT
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] lat_a;
    logic [CFG_W-1:0] lat_b;
    logic [CFG_W-1:0] lat_c;
    logic [CFG_W-1:0] inv0;
    logic [CFG_W-1:0] inv1;
    logic [CFG_W-1:0] inv2;
    logic [CFG_W-1:0] origin;
    logic [4:0]       atoms;
  } cfg_t;

  function automatic logic signed [POS_W-1:0] field(input logic [CFG_W-1:0] r,
                                                    input logic [1:0] k);
    case (k)
      2'd0:    field = r[19:0];
      2'd1:    field = r[39:20];
      default: field = r[59:40];
    endcase
  endfunction
endpackage

@@ src/nearest_lattice_atom_search_top.sv @@
// channel   dir  handshake             payload
// s_axis    in   s_axis_tvalid/tready  op, slot, fractions, position
// m_axis    out  m_axis_tvalid/tready  atom position, site index
// cfg       in   cfg_valid/cfg_ready   register index, write data
// a load item is written while idle and leaves the block ready; a query scans
// one candidate at one atom per cell, else 27 * nat candidates
// each candidate goes through read, three axes of cartesian multiply and sum,
// three distance terms, compare. rst clears control and the configuration
// registers; the basis table is undefined until loaded. a stalled result holds the block.
module nearest_lattice_atom_search_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [nlas_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // basis_slot, frac_x, frac_y, frac_z, pos_x, pos_y, pos_z
  input  logic         s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // atom_x, atom_y, atom_z, site_i, site_j, site_k
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [59:0]  cfg_data
);
  nlas_pkg::cfg_t cfg;

  nlas_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
  );

  nlas_search u_search (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .op(s_axis_tuser),
    .slot(s_axis_tdata[3:0]), .frac(s_axis_tdata[39:4]), .pos(s_axis_tdata[99:40]),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(m_axis_tdata)
  );
endmodule

@@ src/nlas_basis_mem.sv @@
// basis table memory, one write and one registered read port
// depends on nlas_pkg
module nlas_basis_mem #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [$clog2(DEPTH)-1:0]             waddr,
  input  logic [nlas_pkg::BASIS_W-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0]             raddr,
  output logic [nlas_pkg::BASIS_W-1:0]         rdata
);
  logic [nlas_pkg::BASIS_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/nlas_cfg_regs.sv @@
// configuration register file
// depends on nlas_pkg
module nlas_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [nlas_pkg::CFG_W-1:0]   cfg_data,
  output nlas_pkg::cfg_t               cfg
);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lat_a  <= 60'd4096;
      cfg.lat_b  <= 60'd4096 << 20;
      cfg.lat_c  <= 60'd4096 << 40;
      cfg.inv0   <= 60'd65536;
      cfg.inv1   <= 60'd65536 << 20;
      cfg.inv2   <= 60'd65536 << 40;
      cfg.origin <= '0;
      cfg.atoms  <= 5'd1;
    end else if (cfg_valid) begin
      case (nlas_pkg::reg_index_t'(cfg_index))
        nlas_pkg::REG_LATTICE_A: cfg.lat_a  <= cfg_data;
        nlas_pkg::REG_LATTICE_B: cfg.lat_b  <= cfg_data;
        nlas_pkg::REG_LATTICE_C: cfg.lat_c  <= cfg_data;
        nlas_pkg::REG_INVERSE_0: cfg.inv0   <= cfg_data;
        nlas_pkg::REG_INVERSE_1: cfg.inv1   <= cfg_data;
        nlas_pkg::REG_INVERSE_2: cfg.inv2   <= cfg_data;
        nlas_pkg::REG_ORIGIN:    cfg.origin <= cfg_data;
        nlas_pkg::REG_ATOMS:     cfg.atoms  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end
endmodule

@@ src/nlas_search.sv @@
// search sequencer: site rounding and candidate scan over the basis table
// depends on nlas_pkg and nlas_basis_mem
module nlas_search (
  input  logic                             clk,
  input  logic                             rst,
  input  nlas_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic [3:0]                       slot,
  input  logic [nlas_pkg::BASIS_W-1:0]     frac,
  input  logic [3*nlas_pkg::POS_W-1:0]     pos,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [nlas_pkg::OUT_TDATA_W-1:0] res_data
);
  localparam int MAX_BASIS = nlas_pkg::MAX_BASIS;
  localparam int AW = $clog2(MAX_BASIS);
  localparam int CW = nlas_pkg::CART_W;
  localparam int FW = nlas_pkg::FRAC_W;

  nlas_pkg::state_t state, state_next;

  logic signed [nlas_pkg::POS_W-1:0] p [3];
  logic signed [21:0]                d [3];
  logic signed [42:0]                prod [3];
  logic signed [44:0]                acc;
  logic signed [nlas_pkg::IDX_W-1:0] idx [3];
  logic [1:0]  ax, ax_next, dc [3];
  logic [AW:0] b, nat;
  logic [nlas_pkg::BASIS_W-1:0] rdata;
  logic signed [25:0] a [3];
  logic signed [46:0] term [3];
  logic signed [CW-1:0] cand [3], best [3];
  logic signed [CW:0] df;
  logic [31:0] mag;
  logic [nlas_pkg::DIST_W-1:0] sq_sum, best_d;
  logic [63:0] sq;
  logic have, single;
  logic [AW-1:0] raddr;
  logic last_b, last_cell;

  nlas_basis_mem #(.DEPTH(MAX_BASIS)) u_mem (
    .clk(clk), .we(in_valid && in_ready && op == nlas_pkg::OP_LOAD && {1'b0, slot} < 5'(MAX_BASIS)),
    .waddr(slot[AW-1:0]), .wdata(frac), .raddr(raddr), .rdata(rdata)
  );

  // fetch the next entry during compare so it is ready in the read state
  assign raddr = (state == nlas_pkg::ST_CMP) ? (last_b ? '0 : b[AW-1:0] + AW'(1)) : b[AW-1:0];
  assign in_ready = (state == nlas_pkg::ST_IDLE);
  assign last_b = (b == nat - 1'b1);
  assign last_cell = (dc[0] == 2'd2 && dc[1] == 2'd2 && dc[2] == 2'd2);

  always_comb begin
    state_next = state;
    case (state)
      nlas_pkg::ST_IDLE:  if (in_valid && op == nlas_pkg::OP_QUERY) state_next = nlas_pkg::ST_DIFF;
      nlas_pkg::ST_DIFF:  state_next = nlas_pkg::ST_MUL;
      nlas_pkg::ST_MUL:   state_next = nlas_pkg::ST_ROUND;
      nlas_pkg::ST_ROUND: state_next = (ax == 2'd2) ? nlas_pkg::ST_READ : nlas_pkg::ST_MUL;
      nlas_pkg::ST_READ:  state_next = nlas_pkg::ST_CART;
      nlas_pkg::ST_CART:  state_next = nlas_pkg::ST_SUM;
      nlas_pkg::ST_SUM:   state_next = (ax == 2'd2) ? nlas_pkg::ST_DIST : nlas_pkg::ST_CART;
      nlas_pkg::ST_DIST:  state_next = (ax == 2'd2) ? nlas_pkg::ST_CMP : nlas_pkg::ST_DIST;
      nlas_pkg::ST_CMP:   state_next = (single || (last_b && last_cell)) ?
                                       nlas_pkg::ST_OUT : nlas_pkg::ST_READ;
      nlas_pkg::ST_OUT:   if (res_ready) state_next = nlas_pkg::ST_IDLE;
      default:            state_next = nlas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ax_next = ax;
    case (state)
      nlas_pkg::ST_ROUND, nlas_pkg::ST_SUM, nlas_pkg::ST_DIST:
        ax_next = (ax == 2'd2) ? 2'd0 : ax + 2'd1;
      nlas_pkg::ST_MUL, nlas_pkg::ST_CART:
        ax_next = ax;
      default: ax_next = 2'd0;
    endcase
  end

  always_comb begin
    acc = (45'(prod[0]) + 45'(prod[1]) + 45'(prod[2]) + (45'sd1 <<< 27)) >>> 28;
  end

  // distance magnitude stays below 2^32 for any register setting
  always_comb begin
    df = {p[ax][nlas_pkg::POS_W-1], {(CW - nlas_pkg::POS_W){p[ax][nlas_pkg::POS_W-1]}}, p[ax]}
         - {cand[ax][CW-1], cand[ax]};
    mag = df[CW] ? 32'(-df) : df[31:0];
    sq = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nlas_pkg::ST_IDLE;
      ax <= 2'd0;
    end else begin
      state <= state_next;
      ax <= ax_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      nlas_pkg::ST_IDLE: begin
        p[0] <= pos[19:0];
        p[1] <= pos[39:20];
        p[2] <= pos[59:40];
        nat <= (cfg.atoms == 5'd0) ? (AW+1)'(1) :
               ({1'b0, cfg.atoms} > 6'(MAX_BASIS)) ? (AW+1)'(MAX_BASIS) : (AW+1)'(cfg.atoms);
      end
      nlas_pkg::ST_DIFF: begin
        for (int j = 0; j < 3; j++) begin
          d[j] <= 22'(p[j]) - 22'(nlas_pkg::field(cfg.origin, 2'(j)));
        end
        single <= (nat == (AW+1)'(1));
      end
      nlas_pkg::ST_MUL: begin
        for (int j = 0; j < 3; j++) begin
          prod[j] <= 43'(d[j]) * 43'(nlas_pkg::field(
                     (ax == 2'd0) ? cfg.inv0 : (ax == 2'd1) ? cfg.inv1 : cfg.inv2, 2'(j)));
        end
      end
      nlas_pkg::ST_ROUND: begin
        idx[ax] <= (acc > 45'sd2047) ? 12'sd2047 : (acc < -45'sd2048) ? -12'sd2048 : acc[11:0];
        b <= '0;
        have <= 1'b0;
        for (int j = 0; j < 3; j++) dc[j] <= 2'd0;
      end
      nlas_pkg::ST_READ: begin
        for (int j = 0; j < 3; j++) begin
          if (single) begin
            a[j] <= 26'(idx[j]) <<< FW;
          end else begin
            a[j] <= ((26'(idx[j]) + 26'(dc[j]) - 26'sd1) <<< FW)
                    + 26'({1'b0, rdata[12*j +: 12]});
          end
        end
      end
      nlas_pkg::ST_CART: begin
        for (int j = 0; j < 3; j++) begin
          term[j] <= 47'(a[j]) * 47'(nlas_pkg::field(
                     (j == 0) ? cfg.lat_a : (j == 1) ? cfg.lat_b : cfg.lat_c, ax));
        end
      end
      nlas_pkg::ST_SUM: begin
        cand[ax] <= CW'((50'(term[0]) + 50'(term[1]) + 50'(term[2])
                    + (50'(nlas_pkg::field(cfg.origin, ax)) <<< FW)
                    + (50'sd1 <<< (FW - 1))) >>> FW);
        sq_sum <= '0;
      end
      nlas_pkg::ST_DIST: begin
        sq_sum <= sq_sum + nlas_pkg::DIST_W'(sq);
      end
      nlas_pkg::ST_CMP: begin
        if (!have || sq_sum < best_d || single) begin
          have <= 1'b1;
          best_d <= sq_sum;
          for (int j = 0; j < 3; j++) best[j] <= cand[j];
        end
        if (last_b) begin
          b <= '0;
          if (dc[0] != 2'd2) dc[0] <= dc[0] + 2'd1;
          else begin
            dc[0] <= 2'd0;
            if (dc[1] != 2'd2) dc[1] <= dc[1] + 2'd1;
            else begin
              dc[1] <= 2'd0;
              dc[2] <= dc[2] + 2'd1;
            end
          end
        end else begin
          b <= b + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res_valid = (state == nlas_pkg::ST_OUT);

  always_comb begin
    res_data = '0;
    for (int j = 0; j < 3; j++) begin
      res_data[20*j +: 20] = (best[j] > CW'(524287)) ? 20'sd524287 :
                             (best[j] < -CW'(524288)) ? -20'sd524288 : best[j][19:0];
      res_data[60 + 12*j +: 12] = idx[j];
    end
  end
endmodule

@@ src/nlas_checker.sv @@
// port-level checker for the nearest lattice atom search top level
// depends on the macro header; bound to the top level below
`include "nearest_lattice_atom_search_top_macros.svh"
module nlas_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);
  `NLAS_ASSERT_IMPL(no_take_while_result, clk, rst, m_axis_tvalid, !s_axis_tready)
  `NLAS_ASSERT_NEXT(query_starts_busy, clk, rst,
    s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready)
  `NLAS_ASSERT_NEXT(load_stays_ready, clk, rst,
    s_axis_tvalid && s_axis_tready && !s_axis_tuser, s_axis_tready && !m_axis_tvalid)
  `NLAS_ASSERT_NEXT(result_holds, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind nearest_lattice_atom_search_top nlas_checker u_nlas_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
